>>> rtl/core/iol_pkg.sv
// ----------------------------------------------------------------------------
// iol_pkg: shared definitions of the indexed ordered list unit
// Command codes, result status codes, job classes and field widths.
// ----------------------------------------------------------------------------
package iol_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT_AT  = 3'd2,
    CMD_READ_AT    = 3'd3,
    CMD_DELETE_AT  = 3'd4,
    CMD_DUMP       = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  // Job classes handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_ERR  = 3'd0,
    OP_INS  = 3'd1,
    OP_READ = 3'd2,
    OP_DEL  = 3'd3,
    OP_DUMP = 3'd4
  } op_e;

  typedef struct packed {
    op_e     op;
    status_e status;
  } job_ctrl_t;

endpackage

>>> rtl/core/iol_front.sv
// ----------------------------------------------------------------------------
// iol_front: request intake and classification
// Checks each request against the projected list length, resolves the
// effective position and queues a job with the length before and after it.
// ----------------------------------------------------------------------------
module iol_front #(
  parameter int unsigned CAPACITY = iol_pkg::CAPACITY_DEF,
  localparam int unsigned CntW = $clog2(CAPACITY + 1),
  localparam int unsigned IdxW = $clog2(CAPACITY)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         queue_full_i,
  input  logic [iol_pkg::CMD_W-1:0]    cmd_i,
  input  logic [iol_pkg::POS_W-1:0]    position_i,
  input  logic [iol_pkg::VALUE_W-1:0]  value_i,
  output logic                         push_o,
  output iol_pkg::job_ctrl_t           ctrl_o,
  output logic [IdxW-1:0]              pos_o,
  output logic [iol_pkg::VALUE_W-1:0]  value_o,
  output logic [CntW-1:0]              len_before_o,
  output logic [CntW-1:0]              len_after_o
);

  localparam int unsigned CmpW = (CntW > iol_pkg::POS_W) ? CntW : iol_pkg::POS_W;

  logic [CntW-1:0] len_q, len_d;
  logic            accept;
  logic            full;
  logic [CmpW-1:0] pos_ext, len_ext, pos_sel;

  assign accept  = start & ~queue_full_i;
  assign full    = (len_q == CntW'(CAPACITY));
  assign pos_ext = CmpW'(position_i);
  assign len_ext = CmpW'(len_q);

  always_comb begin
    ctrl_o.op     = iol_pkg::OP_ERR;
    ctrl_o.status = iol_pkg::STAT_RANGE;
    pos_sel       = pos_ext;
    len_after_o   = len_q;
    case (cmd_i)
      iol_pkg::CMD_PUSH_FRONT, iol_pkg::CMD_PUSH_BACK, iol_pkg::CMD_INSERT_AT: begin
        if (cmd_i == iol_pkg::CMD_PUSH_FRONT) begin
          pos_sel = '0;
        end else if (cmd_i == iol_pkg::CMD_PUSH_BACK) begin
          pos_sel = len_ext;
        end
        // The full check takes precedence over the position check.
        if (full) begin
          ctrl_o.status = iol_pkg::STAT_FULL;
        end else if (pos_sel <= len_ext) begin
          ctrl_o.op     = iol_pkg::OP_INS;
          ctrl_o.status = iol_pkg::STAT_OK;
          len_after_o   = len_q + CntW'(1);
        end
      end
      iol_pkg::CMD_READ_AT: begin
        if (pos_ext < len_ext) begin
          ctrl_o.op     = iol_pkg::OP_READ;
          ctrl_o.status = iol_pkg::STAT_OK;
        end
      end
      iol_pkg::CMD_DELETE_AT: begin
        if (pos_ext < len_ext) begin
          ctrl_o.op     = iol_pkg::OP_DEL;
          ctrl_o.status = iol_pkg::STAT_OK;
          len_after_o   = len_q - CntW'(1);
        end
      end
      iol_pkg::CMD_DUMP: begin
        if (len_q != '0) begin
          ctrl_o.op     = iol_pkg::OP_DUMP;
          ctrl_o.status = iol_pkg::STAT_OK;
        end
      end
      default: begin
        ctrl_o.op     = iol_pkg::OP_ERR;
        ctrl_o.status = iol_pkg::STAT_RANGE;
      end
    endcase
  end

  assign pos_o        = IdxW'(pos_sel);
  assign value_o      = value_i;
  assign len_before_o = len_q;
  assign push_o       = accept;
  assign len_d        = accept ? len_after_o : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CntW'(CAPACITY))
    else $error("projected length exceeds capacity");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ctrl_o.op == iol_pkg::OP_INS) |=> (len_q == $past(len_q) + CntW'(1)))
    else $error("accepted insert did not grow the projected length");

endmodule

>>> rtl/core/iol_queue.sv
// ----------------------------------------------------------------------------
// iol_queue: short job queue between front end and back end
// A small register FIFO that lets intake continue while the back end works.
// ----------------------------------------------------------------------------
module iol_queue #(
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             valid_o
);

  localparam int unsigned Depth = iol_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [DataW-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("job queue occupancy exceeds its depth");

endmodule

>>> rtl/core/iol_back.sv
// ----------------------------------------------------------------------------
// iol_back: list storage and command sequencer
// Holds the entries in a single-port-write memory and carries out one job at
// a time: shifts for insert and delete, single reads, and full dumps.
// ----------------------------------------------------------------------------
module iol_back #(
  parameter int unsigned CAPACITY = iol_pkg::CAPACITY_DEF,
  localparam int unsigned CntW = $clog2(CAPACITY + 1),
  localparam int unsigned IdxW = $clog2(CAPACITY)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_pop_o,
  input  iol_pkg::job_ctrl_t            job_ctrl_i,
  input  logic [IdxW-1:0]               job_pos_i,
  input  logic [iol_pkg::VALUE_W-1:0]   job_value_i,
  input  logic [CntW-1:0]               job_len_before_i,
  input  logic [CntW-1:0]               job_len_after_i,
  output logic                          result_valid_o,
  output logic [iol_pkg::VALUE_W-1:0]   read_value_o,
  output logic [1:0]                    status_o,
  output logic [iol_pkg::COUNT_W-1:0]   entry_count_o,
  output logic                          last_o
);

  localparam int unsigned CmpW = (CntW > iol_pkg::COUNT_W) ? CntW : iol_pkg::COUNT_W;

  typedef enum logic [4:0] {
    S_IDLE       = 5'b00001,
    S_SHIFT_UP   = 5'b00010,
    S_SHIFT_DOWN = 5'b00100,
    S_READ       = 5'b01000,
    S_DUMP       = 5'b10000
  } state_e;

  state_e                       state_q, state_d;
  logic [CntW-1:0]              idx_q, idx_d;
  logic [IdxW-1:0]              pos_q, pos_d;
  logic [iol_pkg::VALUE_W-1:0]  val_q, val_d;
  logic [CntW-1:0]              len_q, len_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         pend_q, pend_d;
  logic [IdxW-1:0]              pend_addr_q, pend_addr_d;

  logic                         res_valid_q, res_valid_d;
  logic [iol_pkg::VALUE_W-1:0]  res_value_q, res_value_d;
  iol_pkg::status_e             res_status_q, res_status_d;
  logic [CntW-1:0]              res_count_q, res_count_d;
  logic                         res_last_q, res_last_d;
  logic [CmpW-1:0]              count_ext;

  logic [iol_pkg::VALUE_W-1:0]  mem [CAPACITY];
  logic [iol_pkg::VALUE_W-1:0]  rdata_q;
  logic                         mem_we, mem_re;
  logic [IdxW-1:0]              mem_waddr, mem_raddr;
  logic [iol_pkg::VALUE_W-1:0]  mem_wdata;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    val_d        = val_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    job_pop_o    = 1'b0;
    // A shift step that read an entry last cycle writes it back one place over.
    mem_we       = pend_q;
    mem_waddr    = pend_addr_q;
    mem_wdata    = rdata_q;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    res_valid_d  = 1'b0;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    res_last_d   = res_last_q;

    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          pos_d     = job_pos_i;
          val_d     = job_value_i;
          len_d     = job_len_before_i;
          cnt_d     = job_len_after_i;
          case (job_ctrl_i.op)
            iol_pkg::OP_INS: begin
              idx_d   = job_len_before_i;
              state_d = S_SHIFT_UP;
            end
            iol_pkg::OP_DEL: begin
              idx_d   = CntW'(job_pos_i);
              state_d = S_SHIFT_DOWN;
            end
            iol_pkg::OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = job_pos_i;
              state_d   = S_READ;
            end
            iol_pkg::OP_DUMP: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              idx_d     = CntW'(1);
              state_d   = S_DUMP;
            end
            default: begin
              res_valid_d  = 1'b1;
              res_value_d  = '0;
              res_status_d = job_ctrl_i.status;
              res_count_d  = job_len_after_i;
              res_last_d   = 1'b1;
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        if (idx_q > CntW'(pos_q)) begin
          mem_re      = 1'b1;
          mem_raddr   = IdxW'(idx_q - CntW'(1));
          pend_d      = 1'b1;
          pend_addr_d = IdxW'(idx_q);
          idx_d       = idx_q - CntW'(1);
        end else if (!pend_q) begin
          mem_we       = 1'b1;
          mem_waddr    = pos_q;
          mem_wdata    = val_q;
          res_valid_d  = 1'b1;
          res_value_d  = '0;
          res_status_d = iol_pkg::STAT_OK;
          res_count_d  = cnt_q;
          res_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SHIFT_DOWN: begin
        if ((idx_q + CntW'(1)) < len_q) begin
          mem_re      = 1'b1;
          mem_raddr   = IdxW'(idx_q + CntW'(1));
          pend_d      = 1'b1;
          pend_addr_d = IdxW'(idx_q);
          idx_d       = idx_q + CntW'(1);
        end else if (!pend_q) begin
          res_valid_d  = 1'b1;
          res_value_d  = '0;
          res_status_d = iol_pkg::STAT_OK;
          res_count_d  = cnt_q;
          res_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_READ: begin
        res_valid_d  = 1'b1;
        res_value_d  = rdata_q;
        res_status_d = iol_pkg::STAT_OK;
        res_count_d  = cnt_q;
        res_last_d   = 1'b1;
        state_d      = S_IDLE;
      end
      S_DUMP: begin
        // The read data holds the entry just before idx_q.
        res_valid_d  = 1'b1;
        res_value_d  = rdata_q;
        res_status_d = iol_pkg::STAT_OK;
        res_count_d  = cnt_q;
        res_last_d   = (idx_q == len_q);
        if (idx_q == len_q) begin
          state_d = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IdxW'(idx_q);
          idx_d     = idx_q + CntW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    len_q        <= len_d;
    cnt_q        <= cnt_d;
    pend_addr_q  <= pend_addr_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    res_last_q   <= res_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign count_ext      = CmpW'(res_count_q);
  assign result_valid_o = res_valid_q;
  assign read_value_o   = res_value_q;
  assign status_o       = res_status_q;
  assign entry_count_o  = count_ext[iol_pkg::COUNT_W-1:0];
  assign last_o         = res_last_q;

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("memory read and write hit the same entry in one cycle");

  a_pend_in_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SHIFT_UP || state_q == S_SHIFT_DOWN))
    else $error("pending shift write outside a shift sequence");

  a_not_last_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_last_q) |-> (state_q == S_DUMP))
    else $error("non-final result outside a dump");

endmodule

>>> rtl/core/indexed_ordered_list_unit.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list_unit: bounded ordered list of signed 32-bit values
// Per job: errors get a result directly, a read waits for its memory read, an
// insert moves entries p..n-1 up one place and then writes the value, a delete
// moves entries above p down one place, and a dump streams 1 entry per cycle.
// Throughput is set by the back end sequencer and its one memory write port;
// the front end keeps taking requests until the two-entry job queue is full.
// Reset empties the list and the queue; results cannot be stalled.
// ----------------------------------------------------------------------------
module indexed_ordered_list_unit #(
  parameter int unsigned CAPACITY = iol_pkg::CAPACITY_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [iol_pkg::CMD_W-1:0]    cmd_i,
  input  logic [iol_pkg::POS_W-1:0]    position_i,
  input  logic [iol_pkg::VALUE_W-1:0]  value_i,
  output logic                         result_valid_o,
  output logic [iol_pkg::VALUE_W-1:0]  read_value_o,
  output logic [1:0]                   status_o,
  output logic [iol_pkg::COUNT_W-1:0]  entry_count_o,
  output logic                         last_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW  = $clog2(CAPACITY);
  localparam int unsigned JobW  = $bits(iol_pkg::job_ctrl_t) + IdxW
                                  + iol_pkg::VALUE_W + 2 * CntW;

  logic                         queue_full, queue_valid, queue_pop, front_push;
  iol_pkg::job_ctrl_t           front_ctrl, back_ctrl;
  logic [IdxW-1:0]              front_pos, back_pos;
  logic [iol_pkg::VALUE_W-1:0]  front_value, back_value;
  logic [CntW-1:0]              front_len_before, front_len_after;
  logic [CntW-1:0]              back_len_before, back_len_after;
  logic [JobW-1:0]              job_in, job_out;

  iol_front #(
    .CAPACITY(CAPACITY)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .queue_full_i (queue_full),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .push_o       (front_push),
    .ctrl_o       (front_ctrl),
    .pos_o        (front_pos),
    .value_o      (front_value),
    .len_before_o (front_len_before),
    .len_after_o  (front_len_after)
  );

  assign job_in = {front_ctrl, front_pos, front_value, front_len_before, front_len_after};

  iol_queue #(
    .DataW(JobW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (job_in),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .data_o  (job_out),
    .valid_o (queue_valid)
  );

  assign {back_ctrl, back_pos, back_value, back_len_before, back_len_after} = job_out;

  iol_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (queue_valid),
    .job_pop_o        (queue_pop),
    .job_ctrl_i       (back_ctrl),
    .job_pos_i        (back_pos),
    .job_value_i      (back_value),
    .job_len_before_i (back_len_before),
    .job_len_after_i  (back_len_after),
    .result_valid_o   (result_valid_o),
    .read_value_o     (read_value_o),
    .status_o         (status_o),
    .entry_count_o    (entry_count_o),
    .last_o           (last_o)
  );

  assign busy = queue_full;

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for indexed_ordered_list_unit
// Drives push, insert, read, delete and dump requests through the start/busy
// handshake. A walked table covers the edges first, then random fill and drain
// sequences follow. Results are checked against the shadow list or typed rows.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned DEPTH   = iol_pkg::CAPACITY_DEF;
  localparam int unsigned CMD_W   = iol_pkg::CMD_W;
  localparam int unsigned POS_W   = iol_pkg::POS_W;
  localparam int unsigned VALUE_W = iol_pkg::VALUE_W;
  localparam int unsigned COUNT_W = iol_pkg::COUNT_W;
  localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;
  localparam int unsigned RANDOM_PER_PHASE = 95;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    iol_pkg::status_e   status;
    logic [COUNT_W-1:0] count;
    logic               last;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    logic               typed;
    list_result_t       res;
  } dir_row_t;

  localparam list_result_t NO_RES = '0;

  // Rows with typed set carry their result; all others use the shadow list.
  localparam dir_row_t DIRECTED [25] = '{
    '{iol_pkg::CMD_DUMP,       7'd0,   32'h0000_0000, 1'b1,
      '{32'd0, iol_pkg::STAT_RANGE, 7'd0, 1'b1}},
    '{iol_pkg::CMD_READ_AT,    7'd0,   32'h0000_0000, 1'b1,
      '{32'd0, iol_pkg::STAT_RANGE, 7'd0, 1'b1}},
    '{iol_pkg::CMD_DELETE_AT,  7'd0,   32'h0000_0000, 1'b1,
      '{32'd0, iol_pkg::STAT_RANGE, 7'd0, 1'b1}},
    '{iol_pkg::CMD_INSERT_AT,  7'd1,   32'h1111_1111, 1'b1,
      '{32'd0, iol_pkg::STAT_RANGE, 7'd0, 1'b1}},
    '{CMD_BAD_LO,              7'd0,   32'h0000_0000, 1'b1,
      '{32'd0, iol_pkg::STAT_RANGE, 7'd0, 1'b1}},
    '{CMD_BAD_HI,              7'd127, 32'hFFFF_FFFF, 1'b1,
      '{32'd0, iol_pkg::STAT_RANGE, 7'd0, 1'b1}},
    '{iol_pkg::CMD_INSERT_AT,  7'd0,   32'h8000_0000, 1'b1,
      '{32'd0, iol_pkg::STAT_OK,    7'd1, 1'b1}},
    '{iol_pkg::CMD_PUSH_BACK,  7'd0,   32'h7FFF_FFFF, 1'b1,
      '{32'd0, iol_pkg::STAT_OK,    7'd2, 1'b1}},
    '{iol_pkg::CMD_PUSH_FRONT, 7'd0,   32'hFFFF_FFFF, 1'b1,
      '{32'd0, iol_pkg::STAT_OK,    7'd3, 1'b1}},
    '{iol_pkg::CMD_INSERT_AT,  7'd1,   32'h0000_0000, 1'b0, NO_RES},
    '{iol_pkg::CMD_INSERT_AT,  7'd4,   32'h5555_5555, 1'b1,
      '{32'd0, iol_pkg::STAT_OK,    7'd5, 1'b1}},
    '{iol_pkg::CMD_READ_AT,    7'd0,   32'h0000_0000, 1'b0, NO_RES},
    '{iol_pkg::CMD_READ_AT,    7'd4,   32'h0000_0000, 1'b0, NO_RES},
    '{iol_pkg::CMD_READ_AT,    7'd5,   32'h0000_0000, 1'b1,
      '{32'd0, iol_pkg::STAT_RANGE, 7'd5, 1'b1}},
    '{iol_pkg::CMD_READ_AT,    7'd127, 32'h0000_0000, 1'b1,
      '{32'd0, iol_pkg::STAT_RANGE, 7'd5, 1'b1}},
    '{iol_pkg::CMD_DELETE_AT,  7'd4,   32'h0000_0000, 1'b0, NO_RES},
    '{iol_pkg::CMD_PUSH_BACK,  7'd0,   32'hAAAA_AAAA, 1'b0, NO_RES},
    '{iol_pkg::CMD_READ_AT,    7'd4,   32'h0000_0000, 1'b0, NO_RES},
    '{iol_pkg::CMD_DUMP,       7'd0,   32'h0000_0000, 1'b0, NO_RES},
    '{iol_pkg::CMD_DELETE_AT,  7'd0,   32'h0000_0000, 1'b0, NO_RES},
    '{iol_pkg::CMD_DELETE_AT,  7'd4,   32'h0000_0000, 1'b1,
      '{32'd0, iol_pkg::STAT_RANGE, 7'd4, 1'b1}},
    '{iol_pkg::CMD_INSERT_AT,  7'd2,   32'h1234_5678, 1'b0, NO_RES},
    '{iol_pkg::CMD_INSERT_AT,  7'd64,  32'h0000_0000, 1'b1,
      '{32'd0, iol_pkg::STAT_RANGE, 7'd5, 1'b1}},
    '{iol_pkg::CMD_DUMP,       7'd0,   32'h0000_0000, 1'b0, NO_RES},
    '{iol_pkg::CMD_PUSH_FRONT, 7'd0,   32'h0000_0001, 1'b0, NO_RES}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [CMD_W-1:0]   cmd_r = '0;
  logic [POS_W-1:0]   pos_r = '0;
  logic [VALUE_W-1:0] val_r = '0;
  logic               result_valid_o;
  logic [VALUE_W-1:0] read_value_o;
  logic [1:0]         status_o;
  logic [COUNT_W-1:0] entry_count_o;
  logic               last_o;

  // Typed result that travels with the current request.
  logic               req_typed = 1'b0;
  list_result_t       req_res = '0;

  logic [VALUE_W-1:0] list_mem [DEPTH];
  int unsigned        list_len = 0;
  list_result_t       pending_results [$];
  int unsigned        mismatch_count = 0;
  int unsigned        gap_pct = 0;
  bit                 filling = 1'b1;

  indexed_ordered_list_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_r),
    .position_i     (pos_r),
    .value_i        (val_r),
    .result_valid_o (result_valid_o),
    .read_value_o   (read_value_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic void post_result(input logic [VALUE_W-1:0] v,
                                      input iol_pkg::status_e s, input logic l);
    list_result_t r;
    r.value  = v;
    r.status = s;
    r.count  = list_len[COUNT_W-1:0];
    r.last   = l;
    pending_results.push_back(r);
  endfunction

  // Applies one request to the shadow list and queues the results it causes.
  function automatic void predict_list_op(input logic [CMD_W-1:0] op,
                                          input logic [POS_W-1:0] pos,
                                          input logic [VALUE_W-1:0] val);
    int unsigned slot;
    int unsigned k;
    slot = 32'(pos);
    case (op)
      iol_pkg::CMD_PUSH_FRONT, iol_pkg::CMD_PUSH_BACK, iol_pkg::CMD_INSERT_AT: begin
        if (op == iol_pkg::CMD_PUSH_FRONT) slot = 0;
        else if (op == iol_pkg::CMD_PUSH_BACK) slot = list_len;
        if (list_len >= DEPTH) begin
          post_result('0, iol_pkg::STAT_FULL, 1'b1);
        end else if (slot > list_len) begin
          post_result('0, iol_pkg::STAT_RANGE, 1'b1);
        end else begin
          for (k = list_len; k > slot; k--) list_mem[k] = list_mem[k-1];
          list_mem[slot] = val;
          list_len++;
          post_result('0, iol_pkg::STAT_OK, 1'b1);
        end
      end
      iol_pkg::CMD_READ_AT: begin
        if (slot >= list_len) post_result('0, iol_pkg::STAT_RANGE, 1'b1);
        else post_result(list_mem[slot], iol_pkg::STAT_OK, 1'b1);
      end
      iol_pkg::CMD_DELETE_AT: begin
        if (slot >= list_len) begin
          post_result('0, iol_pkg::STAT_RANGE, 1'b1);
        end else begin
          for (k = slot; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
          list_len--;
          post_result('0, iol_pkg::STAT_OK, 1'b1);
        end
      end
      iol_pkg::CMD_DUMP: begin
        if (list_len == 0) begin
          post_result('0, iol_pkg::STAT_RANGE, 1'b1);
        end else begin
          for (k = 0; k < list_len; k++)
            post_result(list_mem[k], iol_pkg::STAT_OK, k + 1 == list_len);
        end
      end
      default: post_result('0, iol_pkg::STAT_RANGE, 1'b1);
    endcase
  endfunction

  // Results are checked first, then a request accepted at this edge is predicted.
  always @(posedge clk_i) begin : result_check
    list_result_t got;
    list_result_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        got.value  = read_value_o;
        got.status = iol_pkg::status_e'(status_o);
        got.count  = entry_count_o;
        got.last   = last_o;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", got));
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value)
            report_mismatch($sformatf("read_value %h, want %h", got.value, want.value));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.count !== want.count)
            report_mismatch($sformatf("entry_count %0d, want %0d", got.count, want.count));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        end
      end
      if (start && !busy) begin
        predict_list_op(cmd_r, pos_r, val_r);
        if (req_typed) begin
          void'(pending_results.pop_back());
          pending_results.push_back(req_res);
        end
      end
    end
  end

  task automatic issue_request(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [VALUE_W-1:0] val, input logic typed,
                               input list_result_t typed_res);
    // Each cycle before the request is idle with a chance of gap_pct percent.
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start     <= 1'b1;
    cmd_r     <= op;
    pos_r     <= pos;
    val_r     <= val;
    req_typed <= typed;
    req_res   <= typed_res;
    do @(posedge clk_i); while (busy);
  endtask

  // Fill and drain passes so that full and empty lists are both reached often.
  task automatic random_request();
    int unsigned n;
    int unsigned roll;
    logic [CMD_W-1:0]   op;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    n = list_len;
    if (filling && n >= DEPTH && $urandom_range(3) == 0) filling = 1'b0;
    if (!filling && n == 0 && $urandom_range(3) == 0) filling = 1'b1;
    roll = $urandom_range(99);
    if (filling) begin
      if (roll < 30) op = iol_pkg::CMD_PUSH_BACK;
      else if (roll < 50) op = iol_pkg::CMD_PUSH_FRONT;
      else if (roll < 75) op = iol_pkg::CMD_INSERT_AT;
      else if (roll < 83) op = iol_pkg::CMD_READ_AT;
      else if (roll < 88) op = iol_pkg::CMD_DELETE_AT;
      else if (roll < 94) op = iol_pkg::CMD_DUMP;
      else op = (roll[0]) ? CMD_BAD_HI : CMD_BAD_LO;
    end else begin
      if (roll < 48) op = iol_pkg::CMD_DELETE_AT;
      else if (roll < 63) op = iol_pkg::CMD_READ_AT;
      else if (roll < 71) op = iol_pkg::CMD_INSERT_AT;
      else if (roll < 75) op = iol_pkg::CMD_PUSH_BACK;
      else if (roll < 79) op = iol_pkg::CMD_PUSH_FRONT;
      else if (roll < 94) op = iol_pkg::CMD_DUMP;
      else op = (roll[0]) ? CMD_BAD_HI : CMD_BAD_LO;
    end
    case ($urandom_range(9))
      0: pos = POS_W'($urandom_range(127));
      1: pos = POS_W'(n);
      default: begin
        if (op == iol_pkg::CMD_INSERT_AT) pos = POS_W'($urandom_range(n));
        else pos = (n == 0) ? '0 : POS_W'($urandom_range(n - 1));
      end
    endcase
    case ($urandom_range(7))
      0: val = 32'h8000_0000;
      1: val = 32'h7FFF_FFFF;
      2: val = 32'h0000_0000;
      3: val = 32'hFFFF_FFFF;
      default: val = $urandom;
    endcase
    issue_request(op, pos, val, 1'b0, NO_RES);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 15;
    foreach (DIRECTED[i])
      issue_request(DIRECTED[i].op, DIRECTED[i].pos, DIRECTED[i].val, DIRECTED[i].typed,
                    DIRECTED[i].res);
    repeat (RANDOM_PER_PHASE) random_request();
    gap_pct = 88;
    repeat (RANDOM_PER_PHASE) random_request();
    gap_pct = 0;
    repeat (RANDOM_PER_PHASE) random_request();
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
